[rtl/mflg_pkg.sv]
// mflg_pkg: shared constants and the sequencer state type for the level-graph max-flow core
// no dependencies; imported by max_flow_level_graph_core and max_flow_level_graph_core_tb
`default_nettype none

package mflg_pkg;

   localparam int NODES           = 1024;
   localparam int NODE_W          = 10;
   localparam int LVL_W           = NODE_W + 1;
   localparam int CAP_W           = 31;
   localparam int RES_W           = 32;
   localparam int FLOW_W          = 43;
   localparam int QI_W            = NODE_W + 1;
   localparam int DEF_MAX_EDGES   = 4096;
   localparam int REQ_TDATA_W     = 56;
   localparam int RSP_TDATA_W     = 48;

   localparam logic CSR_SOURCE = 1'b0;
   localparam logic CSR_SINK   = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_LD_A,
      ST_LD_B,
      ST_START,
      ST_CLR_LVL,
      ST_BFS_INIT,
      ST_BFS_POP,
      ST_BFS_U,
      ST_BFS_H,
      ST_BFS_ARC,
      ST_BFS_T,
      ST_BFS_V,
      ST_BFS_CHK,
      ST_P_INIT,
      ST_P_LOAD,
      ST_P_STEP,
      ST_P_ARC,
      ST_P_V,
      ST_P_RET1,
      ST_P_RET2,
      ST_EMIT,
      ST_CLR_HEAD
   } state_type;

endpackage

`default_nettype wire

[rtl/max_flow_level_graph_core.sv]
// max_flow_level_graph_core: edge loader and level-graph (Dinic) max-flow sequencer
// depends on mflg_pkg; all graph state in on-chip synchronous memories
//
//  channel | dir | handshake            | word
//  req     | in  | req_tvalid/tready    | tdata: from_node, to_node, edge_capacity; tlast: last_edge
//  rsp     | out | rsp_tvalid/tready    | tdata: max_flow; tuser: edges_dropped
//  csr     | in  | csr_valid/csr_ready  | csr_index selects source (0) or sink (1), csr_wdata
//
// each edge word makes two read-modify-writes of the adjacency head memory, in ST_LD_A and
// ST_LD_B, with req_tready low; after the last word, each phase clears the level memory, then
// scans the arcs in the search and runs the push with its arc steps and returns
// reset, and each emitted result, start a clear of every head entry with req_tready low
// the result sits in an output register; a stalled rsp holds the next result back in ST_EMIT
`default_nettype none

module max_flow_level_graph_core
   import mflg_pkg::*;
#(
   parameter int MAX_EDGES = DEF_MAX_EDGES
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,   // from_node, to_node, edge_capacity
   input  wire logic                   req_tlast,   // last_edge
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,   // max_flow
   output logic                        rsp_tuser,   // edges_dropped
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic                   csr_index,
   input  wire logic [NODE_W-1:0]      csr_wdata
);

   localparam int ARCS   = 2 * MAX_EDGES;
   localparam int ARC_W  = (ARCS > 1) ? $clog2(ARCS) : 1;
   localparam int LINK_W = $clog2(ARCS + 1);

   typedef struct packed {
      logic [NODE_W-1:0] node;
      logic [LINK_W-1:0] cursor;
      logic [RES_W-1:0]  budget;
      logic              inf;
      logic [FLOW_W-1:0] out;
      logic [ARC_W-1:0]  arc;
      logic [LVL_W-1:0]  lvl;
   } frame_type;

   // memories
   logic [LINK_W-1:0] head_mem [NODES];
   logic [LINK_W-1:0] next_mem [ARCS];
   logic [NODE_W-1:0] tgt_mem  [ARCS];
   logic [RES_W-1:0]  res_mem  [ARCS];
   logic [LVL_W-1:0]  lvl_mem  [NODES];
   logic [NODE_W-1:0] q_mem    [NODES];
   frame_type         stk_mem  [NODES];

   logic [NODE_W-1:0] head_ra, head_wa, lvl_ra, lvl_wa, q_ra, q_wa, stk_ra, stk_wa;
   logic              head_we, lvl_we, q_we, stk_we, link_we, res_we;
   logic [LINK_W-1:0] head_wd, head_rd, next_wd, next_rd;
   logic [LVL_W-1:0]  lvl_wd, lvl_rd;
   logic [NODE_W-1:0] q_wd, q_rd, tgt_wd, tgt_rd;
   logic [ARC_W-1:0]  arc_ra, arc_wa;
   logic [RES_W-1:0]  res_wd, res_rd;
   frame_type         stk_wd, stk_rd;

   state_type         state_ff, state_in;
   logic [NODE_W-1:0] cnt_ff, cnt_in, src_ff, src_in, snk_ff, snk_in;
   logic [NODE_W-1:0] from_ff, from_in, to_ff, to_in, v_ff, v_in, top_ff, top_in;
   logic [CAP_W-1:0]  cap_ff, cap_in;
   logic              last_ff, last_in, dropped_ff, dropped_in;
   logic [LINK_W-1:0] arc_count_ff, arc_count_in, cursor_ff, cursor_in;
   logic [FLOW_W-1:0] flow_ff, flow_in, ret_ff, ret_in;
   logic [QI_W-1:0]   qh_ff, qh_in, qt_ff, qt_in;
   logic [LVL_W-1:0]  lu_ff, lu_in;
   frame_type         frm_ff, frm_in;
   logic [ARC_W-1:0]  cur_arc_ff, cur_arc_in;
   logic [RES_W-1:0]  resv_ff, resv_in;
   logic              rsp_valid_ff, rsp_valid_in, rsp_drop_ff, rsp_drop_in;
   logic [FLOW_W-1:0] rsp_flow_ff, rsp_flow_in;

   logic              fdone;
   logic [FLOW_W-1:0] ret_v;
   logic [LINK_W-1:0] link1;
   frame_type         child;

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_wa] <= head_wd;
      end
      head_rd <= head_mem[head_ra];
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         next_mem[arc_wa] <= next_wd;
         tgt_mem[arc_wa]  <= tgt_wd;
      end
      if (res_we) begin
         res_mem[arc_wa] <= res_wd;
      end
      next_rd <= next_mem[arc_ra];
      tgt_rd  <= tgt_mem[arc_ra];
      res_rd  <= res_mem[arc_ra];
   end

   always_ff @(posedge clock) begin
      if (lvl_we) begin
         lvl_mem[lvl_wa] <= lvl_wd;
      end
      lvl_rd <= lvl_mem[lvl_ra];
   end

   always_ff @(posedge clock) begin
      if (q_we) begin
         q_mem[q_wa] <= q_wd;
      end
      q_rd <= q_mem[q_ra];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_wa] <= stk_wd;
      end
      stk_rd <= stk_mem[stk_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR_HEAD;
         cnt_ff       <= '0;
         src_ff       <= '0;
         snk_ff       <= NODE_W'(1);
         arc_count_ff <= '0;
         dropped_ff   <= 1'b0;
         flow_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         src_ff       <= src_in;
         snk_ff       <= snk_in;
         arc_count_ff <= arc_count_in;
         dropped_ff   <= dropped_in;
         flow_ff      <= flow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      from_ff     <= from_in;
      to_ff       <= to_in;
      cap_ff      <= cap_in;
      last_ff     <= last_in;
      v_ff        <= v_in;
      top_ff      <= top_in;
      cursor_ff   <= cursor_in;
      ret_ff      <= ret_in;
      qh_ff       <= qh_in;
      qt_ff       <= qt_in;
      lu_ff       <= lu_in;
      frm_ff      <= frm_in;
      cur_arc_ff  <= cur_arc_in;
      resv_ff     <= resv_in;
      rsp_drop_ff <= rsp_drop_in;
      rsp_flow_ff <= rsp_flow_in;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      src_in       = src_ff;
      snk_in       = snk_ff;
      from_in      = from_ff;
      to_in        = to_ff;
      cap_in       = cap_ff;
      last_in      = last_ff;
      v_in         = v_ff;
      top_in       = top_ff;
      arc_count_in = arc_count_ff;
      cursor_in    = cursor_ff;
      flow_in      = flow_ff;
      ret_in       = ret_ff;
      qh_in        = qh_ff;
      qt_in        = qt_ff;
      lu_in        = lu_ff;
      frm_in       = frm_ff;
      cur_arc_in   = cur_arc_ff;
      resv_in      = resv_ff;
      dropped_in   = dropped_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_drop_in  = rsp_drop_ff;
      rsp_flow_in  = rsp_flow_ff;

      head_ra = '0;  head_we = 1'b0; head_wa = '0; head_wd = '0;
      lvl_ra  = '0;  lvl_we  = 1'b0; lvl_wa  = '0; lvl_wd  = '0;
      q_ra    = '0;  q_we    = 1'b0; q_wa    = '0; q_wd    = '0;
      stk_ra  = '0;  stk_we  = 1'b0; stk_wa  = '0; stk_wd  = frm_ff;
      arc_ra  = '0;  arc_wa  = '0;   link_we = 1'b0; res_we = 1'b0;
      next_wd = '0;  tgt_wd  = '0;   res_wd  = '0;

      fdone = 1'b0;
      ret_v = '0;
      link1 = arc_count_ff + LINK_W'(1);
      child = frm_ff;

      req_tready = (state_ff == ST_IDLE);
      csr_ready  = 1'b1;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_SOURCE: src_in = csr_wdata;
            CSR_SINK:   snk_in = csr_wdata;
            default:    src_in = src_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               from_in = req_tdata[NODE_W-1:0];
               to_in   = req_tdata[2*NODE_W-1:NODE_W];
               cap_in  = req_tdata[2*NODE_W+CAP_W-1:2*NODE_W];
               last_in = req_tlast;
               head_ra = req_tdata[NODE_W-1:0];
               if (arc_count_ff <= LINK_W'(ARCS - 2)) begin
                  state_in = ST_LD_A;
               end else begin
                  dropped_in = 1'b1;
                  state_in   = req_tlast ? ST_START : ST_IDLE;
               end
            end
         end
         ST_LD_A: begin
            link_we = 1'b1;
            res_we  = 1'b1;
            arc_wa  = arc_count_ff[ARC_W-1:0];
            next_wd = head_rd;
            tgt_wd  = to_ff;
            res_wd  = RES_W'(cap_ff);
            head_we = 1'b1;
            head_wa = from_ff;
            head_wd = link1;
            head_ra = to_ff;
            state_in = ST_LD_B;
         end
         ST_LD_B: begin
            link_we = 1'b1;
            res_we  = 1'b1;
            arc_wa  = link1[ARC_W-1:0];
            // self loop: head of this node was just rewritten
            next_wd = (to_ff == from_ff) ? link1 : head_rd;
            tgt_wd  = from_ff;
            res_wd  = '0;
            head_we = 1'b1;
            head_wa = to_ff;
            head_wd = arc_count_ff + LINK_W'(2);
            arc_count_in = arc_count_ff + LINK_W'(2);
            state_in = last_ff ? ST_START : ST_IDLE;
         end
         ST_START: begin
            cnt_in   = '0;
            state_in = (src_ff == snk_ff) ? ST_EMIT : ST_CLR_LVL;
         end
         ST_CLR_LVL: begin
            lvl_we = 1'b1;
            lvl_wa = cnt_ff;
            lvl_wd = '0;
            cnt_in = cnt_ff + NODE_W'(1);
            if (cnt_ff == NODE_W'(NODES - 1)) begin
               state_in = ST_BFS_INIT;
            end
         end
         ST_BFS_INIT: begin
            lvl_we = 1'b1;
            lvl_wa = src_ff;
            lvl_wd = LVL_W'(1);
            q_we   = 1'b1;
            q_wa   = '0;
            q_wd   = src_ff;
            qh_in  = '0;
            qt_in  = QI_W'(1);
            state_in = ST_BFS_POP;
         end
         ST_BFS_POP: begin
            if (qh_ff < qt_ff) begin
               q_ra     = qh_ff[NODE_W-1:0];
               qh_in    = qh_ff + QI_W'(1);
               state_in = ST_BFS_U;
            end else begin
               lvl_ra   = snk_ff;
               state_in = ST_BFS_CHK;
            end
         end
         ST_BFS_U: begin
            head_ra  = q_rd;
            lvl_ra   = q_rd;
            state_in = ST_BFS_H;
         end
         ST_BFS_H: begin
            cursor_in = head_rd;
            lu_in     = lvl_rd;
            state_in  = ST_BFS_ARC;
         end
         ST_BFS_ARC: begin
            if (cursor_ff == '0) begin
               state_in = ST_BFS_POP;
            end else begin
               arc_ra   = ARC_W'(cursor_ff - LINK_W'(1));
               state_in = ST_BFS_T;
            end
         end
         ST_BFS_T: begin
            cursor_in = next_rd;
            if (res_rd != '0) begin
               lvl_ra   = tgt_rd;
               v_in     = tgt_rd;
               state_in = ST_BFS_V;
            end else begin
               state_in = ST_BFS_ARC;
            end
         end
         ST_BFS_V: begin
            if (lvl_rd == '0) begin
               lvl_we = 1'b1;
               lvl_wa = v_ff;
               lvl_wd = lu_ff + LVL_W'(1);
               if (qt_ff < QI_W'(NODES)) begin
                  q_we  = 1'b1;
                  q_wa  = qt_ff[NODE_W-1:0];
                  q_wd  = v_ff;
                  qt_in = qt_ff + QI_W'(1);
               end
            end
            state_in = ST_BFS_ARC;
         end
         ST_BFS_CHK: begin
            state_in = (lvl_rd != '0) ? ST_P_INIT : ST_EMIT;
         end
         ST_P_INIT: begin
            head_ra  = src_ff;
            lvl_ra   = src_ff;
            state_in = ST_P_LOAD;
         end
         ST_P_LOAD: begin
            frm_in.node   = src_ff;
            frm_in.cursor = head_rd;
            frm_in.budget = '0;
            frm_in.inf    = 1'b1;
            frm_in.out    = '0;
            frm_in.arc    = '0;
            frm_in.lvl    = lvl_rd;
            top_in        = '0;
            state_in      = ST_P_STEP;
         end
         ST_P_STEP: begin
            if (frm_ff.node == snk_ff) begin
               ret_v = FLOW_W'(frm_ff.budget);
               fdone = 1'b1;
            end else if ((!frm_ff.inf && frm_ff.budget == '0) || frm_ff.cursor == '0) begin
               // budget used up or no arcs left; a node that passed nothing on leaves the level graph
               if (frm_ff.out == '0) begin
                  lvl_we = 1'b1;
                  lvl_wa = frm_ff.node;
                  lvl_wd = '0;
               end
               ret_v = frm_ff.out;
               fdone = 1'b1;
            end else begin
               arc_ra     = ARC_W'(frm_ff.cursor - LINK_W'(1));
               cur_arc_in = ARC_W'(frm_ff.cursor - LINK_W'(1));
               state_in   = ST_P_ARC;
            end
            if (fdone) begin
               if (top_ff == '0) begin
                  flow_in  = flow_ff + ret_v;
                  cnt_in   = '0;
                  state_in = ST_CLR_LVL;
               end else begin
                  arc_ra   = frm_ff.arc;
                  stk_ra   = top_ff - NODE_W'(1);
                  ret_in   = ret_v;
                  top_in   = top_ff - NODE_W'(1);
                  state_in = ST_P_RET1;
               end
            end
         end
         ST_P_ARC: begin
            frm_in.cursor = next_rd;
            resv_in       = res_rd;
            if (res_rd != '0 && frm_ff.lvl != '0 && top_ff != NODE_W'(NODES - 1)) begin
               lvl_ra   = tgt_rd;
               head_ra  = tgt_rd;
               v_in     = tgt_rd;
               state_in = ST_P_V;
            end else begin
               state_in = ST_P_STEP;
            end
         end
         ST_P_V: begin
            if (lvl_rd == frm_ff.lvl + LVL_W'(1)) begin
               stk_we       = 1'b1;
               stk_wa       = top_ff;
               stk_wd       = frm_ff;
               child.node   = v_ff;
               child.cursor = head_rd;
               child.budget = (frm_ff.inf || resv_ff < frm_ff.budget) ? resv_ff : frm_ff.budget;
               child.inf    = 1'b0;
               child.out    = '0;
               child.arc    = cur_arc_ff;
               child.lvl    = lvl_rd;
               frm_in       = child;
               top_in       = top_ff + NODE_W'(1);
            end
            state_in = ST_P_STEP;
         end
         ST_P_RET1: begin
            res_we     = 1'b1;
            arc_wa     = frm_ff.arc;
            res_wd     = res_rd - ret_ff[RES_W-1:0];
            arc_ra     = frm_ff.arc ^ ARC_W'(1);
            cur_arc_in = frm_ff.arc ^ ARC_W'(1);
            frm_in     = stk_rd;
            if (!stk_rd.inf) begin
               frm_in.budget = stk_rd.budget - ret_ff[RES_W-1:0];
            end
            frm_in.out = stk_rd.out + ret_ff;
            state_in   = ST_P_RET2;
         end
         ST_P_RET2: begin
            res_we   = 1'b1;
            arc_wa   = cur_arc_ff;
            res_wd   = res_rd + ret_ff[RES_W-1:0];
            state_in = ST_P_STEP;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_flow_in  = flow_ff;
               rsp_drop_in  = dropped_ff;
               flow_in      = '0;
               dropped_in   = 1'b0;
               arc_count_in = '0;
               cnt_in       = '0;
               state_in     = ST_CLR_HEAD;
            end
         end
         ST_CLR_HEAD: begin
            head_we = 1'b1;
            head_wa = cnt_ff;
            head_wd = '0;
            cnt_in  = cnt_ff + NODE_W'(1);
            if (cnt_ff == NODE_W'(NODES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_flow_ff);
   assign rsp_tuser  = rsp_drop_ff;

   a_arc_bound: assert property (@(posedge clock) disable iff (reset)
      arc_count_ff <= LINK_W'(ARCS))
      else $error("arc count beyond table");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BFS_POP) |-> (qh_ff <= qt_ff && qt_ff <= QI_W'(NODES)))
      else $error("search queue pointers out of order");

   a_pop_depth: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_P_RET1) |-> (top_ff == $past(top_ff) - NODE_W'(1)))
      else $error("return without stack pop");

   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_EMIT))
      else $error("result word raised outside emit");

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LD_B) |=> (state_ff == ST_IDLE || state_ff == ST_START))
      else $error("edge load did not finish");

endmodule

`default_nettype wire

[test/max_flow_level_graph_core_tb.sv]
// max_flow_level_graph_core_tb: self-checking bench for the level-graph max-flow core
// streams random and directed edge graphs, predicts each total flow with its own Dinic
// solver and checks every result word; depends on mflg_pkg and max_flow_level_graph_core
`default_nettype none

module max_flow_level_graph_core_tb;
   import mflg_pkg::*;

   localparam int ARC_SLOTS = 2 * DEF_MAX_EDGES;
   localparam bit [CAP_W-1:0] CAP_MAX = {CAP_W{1'b1}};

   typedef struct packed {
      bit [FLOW_W-1:0] flow;
      bit              dropped;
   } flow_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tlast = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic                   csr_index = CSR_SOURCE;
   logic [NODE_W-1:0]      csr_wdata = '0;

   max_flow_level_graph_core uut (.*);

   always #2 clock = ~clock;

   // solver state
   int unsigned     adj_head[NODES];
   int unsigned     arc_nxt[ARC_SLOTS];
   int unsigned     arc_tgt[ARC_SLOTS];
   bit [31:0]       arc_res[ARC_SLOTS];
   int unsigned     lvl[NODES];
   int unsigned     bfs_q[NODES];
   int unsigned     fr_node[NODES];
   int unsigned     fr_cur[NODES];
   bit [63:0]       fr_budget[NODES];
   int unsigned     fr_arc[NODES];
   bit [63:0]       fr_out[NODES];
   int unsigned     n_arcs;
   bit [63:0]       flow_acc;
   bit              drop_flag;
   bit [NODE_W-1:0] cfg_src = 0;
   bit [NODE_W-1:0] cfg_snk = 1;

   flow_result_type flow_expected[$];
   int              errors = 0;
   int              mismatches = 0;
   int              items_sent = 0;
   bit              steady = 1'b0;

   function automatic void clear_graph();
      foreach (adj_head[i]) begin
         adj_head[i] = 0;
         lvl[i] = 0;
      end
      n_arcs = 0;
      flow_acc = 0;
      drop_flag = 0;
   endfunction

   function automatic void link(int unsigned f, int unsigned t, bit [31:0] c);
      arc_tgt[n_arcs] = t;
      arc_res[n_arcs] = c;
      arc_nxt[n_arcs] = adj_head[f];
      adj_head[f] = n_arcs + 1;
      n_arcs++;
   endfunction

   function automatic bit label_levels();
      int unsigned hd, tl, u, p, v;
      hd = 0;
      tl = 1;
      foreach (lvl[i]) lvl[i] = 0;
      lvl[cfg_src] = 1;
      bfs_q[0] = 32'(cfg_src);
      while (hd < tl) begin
         u = bfs_q[hd];
         hd++;
         for (p = adj_head[u]; p != 0; p = arc_nxt[p-1]) begin
            v = arc_tgt[p-1];
            if (arc_res[p-1] != 0 && lvl[v] == 0) begin
               lvl[v] = lvl[u] + 1;
               if (tl < NODES) begin
                  bfs_q[tl] = v;
                  tl++;
               end
            end
         end
      end
      return lvl[cfg_snk] != 0;
   endfunction

   function automatic bit [63:0] push_blocking();
      int unsigned top, u, a, v;
      bit [63:0]   ret, b;
      bit          done;
      top = 0;
      fr_node[0] = 32'(cfg_src);
      fr_cur[0] = adj_head[cfg_src];
      fr_budget[0] = '1;
      fr_arc[0] = 0;
      fr_out[0] = 0;
      forever begin
         u = fr_node[top];
         done = 0;
         ret = 0;
         if (u == cfg_snk) begin
            ret = fr_budget[top];
            done = 1;
         end else if (fr_budget[top] == 0 || fr_cur[top] == 0) begin
            if (fr_out[top] == 0) lvl[u] = 0;
            ret = fr_out[top];
            done = 1;
         end else begin
            a = fr_cur[top] - 1;
            v = arc_tgt[a];
            fr_cur[top] = arc_nxt[a];
            if (arc_res[a] != 0 && lvl[u] != 0 && lvl[v] == lvl[u] + 1 && top + 1 < NODES) begin
               b = fr_budget[top];
               if (64'(arc_res[a]) < b) b = 64'(arc_res[a]);
               top++;
               fr_node[top] = v;
               fr_cur[top] = adj_head[v];
               fr_budget[top] = b;
               fr_arc[top] = a;
               fr_out[top] = 0;
            end
         end
         if (done) begin
            if (top == 0) return ret;
            a = fr_arc[top];
            top--;
            arc_res[a] = arc_res[a] - ret[31:0];
            arc_res[a ^ 1] = arc_res[a ^ 1] + ret[31:0];
            fr_budget[top] = fr_budget[top] - ret;
            fr_out[top] = fr_out[top] + ret;
         end
      end
   endfunction

   function automatic void predict_edge(bit [NODE_W-1:0] f, bit [NODE_W-1:0] t,
                                        bit [CAP_W-1:0] c, bit last);
      flow_result_type r;
      if (n_arcs + 2 <= ARC_SLOTS) begin
         link(32'(f), 32'(t), {1'b0, c});
         link(32'(t), 32'(f), 0);
      end else begin
         drop_flag = 1;
      end
      if (last) begin
         if (cfg_src != cfg_snk)
            while (label_levels()) flow_acc += push_blocking();
         r.flow = flow_acc[FLOW_W-1:0];
         r.dropped = drop_flag;
         flow_expected.push_back(r);
         clear_graph();
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 38);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (flow_expected.size() == 0) begin
            errors++;
            if (mismatches < 10)
               $display("unexpected result word flow=%0d", rsp_tdata[FLOW_W-1:0]);
            mismatches++;
         end else begin
            flow_result_type e;
            e = flow_expected.pop_front();
            if (rsp_tdata[FLOW_W-1:0] !== e.flow || rsp_tuser !== e.dropped) begin
               errors++;
               if (mismatches < 10)
                  $display("mismatch: expected flow=%0d dropped=%0d, got flow=%0d dropped=%0d",
                           e.flow, e.dropped, rsp_tdata[FLOW_W-1:0], rsp_tuser);
               mismatches++;
            end
         end
      end
   end

   task automatic send_edge(bit [NODE_W-1:0] f, bit [NODE_W-1:0] t, bit [CAP_W-1:0] c,
                            bit last);
      if (!steady && $urandom_range(99) < 38) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < 38) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_TDATA_W'({c, t, f});
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      predict_edge(f, t, c, last);
      items_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (flow_expected.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, bit [NODE_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_SOURCE) cfg_src = val;
      else cfg_snk = val;
      @(posedge clock);
   endtask

   task automatic set_terminals(bit [NODE_W-1:0] s, bit [NODE_W-1:0] t);
      drain();
      write_reg(CSR_SOURCE, s);
      write_reg(CSR_SINK, t);
   endtask

   task automatic test_directed();
      // reset terminals: 0 -> 1, single edge at full capacity
      send_edge(0, 1, CAP_MAX, 1);
      // zero capacity, self loop, parallel and opposite edges
      send_edge(0, 1, 0, 0);
      send_edge(1, 1, 77, 0);
      send_edge(0, 0, 50, 1);
      send_edge(0, 1, 10, 0);
      send_edge(0, 1, 20, 0);
      send_edge(1, 0, 30, 0);
      send_edge(0, 2, CAP_MAX, 0);
      send_edge(2, 1, 5, 1);
      set_terminals(1023, 0);
      send_edge(1023, 512, CAP_MAX, 0);
      send_edge(512, 0, CAP_MAX, 0);
      send_edge(1023, 0, CAP_MAX, 0);
      send_edge(341, 682, 1, 1);
      // source equals sink
      set_terminals(1023, 1023);
      send_edge(1023, 1023, 9, 0);
      send_edge(1023, 4, 9, 1);
      set_terminals(3, 1023);
      // diamond with a cross edge between the two middle nodes
      send_edge(3, 10, 100, 0);
      send_edge(3, 11, 100, 0);
      send_edge(10, 11, 100, 0);
      send_edge(10, 1023, 100, 0);
      send_edge(11, 1023, 100, 1);
      // sink unreachable
      send_edge(1023, 3, 100, 1);
   endtask

   task automatic test_table_full();
      set_terminals(0, 1);
      send_edge(0, 1, 5, 0);
      for (int i = 0; i < DEF_MAX_EDGES + 3; i++)
         send_edge(700, 701, CAP_W'($urandom_range(9)), i == DEF_MAX_EDGES + 2);
   endtask

   task automatic test_random(int target);
      bit [NODE_W-1:0] pool[6];
      int n;
      while (items_sent < target) begin
         if ($urandom_range(9) == 0) begin
            case ($urandom_range(3))
               0: set_terminals(NODE_W'($urandom_range(1023)), NODE_W'($urandom_range(1023)));
               1: set_terminals(0, 1023);
               2: set_terminals(1023, 0);
               default: set_terminals(NODE_W'($urandom_range(1023)),
                                      NODE_W'($urandom_range(15)));
            endcase
         end
         if ($urandom_range(19) == 0) drain();
         pool[0] = cfg_src;
         pool[1] = cfg_snk;
         for (int i = 2; i < 6; i++) pool[i] = NODE_W'($urandom_range(1023));
         n = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
         for (int i = 0; i < n; i++) begin
            bit [NODE_W-1:0] f, t;
            bit [CAP_W-1:0] c;
            if ($urandom_range(99) < 85) begin
               f = pool[$urandom_range(5)];
               t = pool[$urandom_range(5)];
            end else begin
               f = NODE_W'($urandom_range(1023));
               t = NODE_W'($urandom_range(1023));
            end
            case ($urandom_range(9))
               0: c = 0;
               1: c = CAP_MAX;
               2: c = CAP_W'($urandom());
               default: c = CAP_W'($urandom_range(1, 100));
            endcase
            send_edge(f, t, c, i == n - 1);
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      clear_graph();
      test_directed();
      test_table_full();
      steady = 1'b1;
      test_random(items_sent + 300);
      steady = 1'b0;
      test_random(items_sent + 1000);
      drain();
      repeat (2000) @(posedge clock);
      if (errors == 0 && flow_expected.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #80000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire

[filelist.f]
rtl/mflg_pkg.sv
rtl/max_flow_level_graph_core.sv
test/max_flow_level_graph_core_tb.sv
